/* src/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* src/hcd_pkg.sv */
// Package for the cell Hamming distance block: constants, codes and types
package hcd_pkg;

	localparam int BYTES_PER_ITEM = 8;
	localparam int LANES = (BYTES_PER_ITEM > 8) ? 8 : BYTES_PER_ITEM;

	localparam int DATA_W  = 64;
	localparam int COUNT_W = 4;
	localparam int DIST_W  = 31;
	localparam int CNT_W   = 7;   // per-item count, 0..64
	localparam int CFG_W   = 3;   // widest register

	localparam logic [DIST_W-1:0] TOTAL_MAX   = {DIST_W{1'b1}};
	localparam logic [DATA_W-1:0] PAIR_MASK   = {8{8'h55}};
	localparam logic [DATA_W-1:0] NIBBLE_MASK = {8{8'h11}};

	// Register indexes
	localparam logic REG_CELL_SIZE = 1'b0;
	localparam logic REG_DIFF_MODE = 1'b1;

	// Supported cell sizes
	localparam logic [2:0] CELL_BIT    = 3'd1;
	localparam logic [2:0] CELL_PAIR   = 3'd2;
	localparam logic [2:0] CELL_NIBBLE = 3'd4;

	// Result status codes
	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_UNSUPPORTED = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0] cell_size;
		logic       diff_mode;
	} hcd_cfg_t;

	// Classified item passed from the front to the back
	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             supported;
		logic             last;
	} hcd_entry_t;

	// Number of set bits in one byte
	function automatic logic [3:0] byte_ones(input logic [7:0] b);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'b000, b[k]};
		end
		return n;
	endfunction

endpackage

/* src/hcd_if.sv */
// Item and result channel interfaces
interface hcd_item_if import hcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  operand_a;
	logic [DATA_W-1:0]  operand_b;
	logic [COUNT_W-1:0] byte_count;
	logic               last;

	modport source (output valid, operand_a, operand_b, byte_count, last, input ready);
	modport sink   (input valid, operand_a, operand_b, byte_count, last, output ready);
endinterface

interface hcd_result_if import hcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic              status;

	modport source (output valid, distance, status, input ready);
	modport sink   (input valid, distance, status, output ready);
endinterface

/* src/hcd_front.sv */
// Front part: masks and combines operands, reduces cells, counts them per item
module hcd_front import hcd_pkg::*; (
	input  logic [DATA_W-1:0]  operand_a,
	input  logic [DATA_W-1:0]  operand_b,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic               last,
	input  hcd_cfg_t           cfg,
	output hcd_entry_t         entry
);

	logic [DATA_W-1:0] mixed;
	logic [DATA_W-1:0] masked;
	logic [DATA_W-1:0] spread;
	logic [DATA_W-1:0] cells;
	logic              supported;
	logic [3:0]        lane_cnt [8];

	assign mixed = cfg.diff_mode ? (operand_a ^ operand_b) : operand_a;

	// Byte lanes at or above the (clamped) count are dropped
	genvar i;
	generate
		for (i = 0; i < 8; i++) begin : g_lane
			logic keep;
			assign keep = (i < LANES) && (byte_count > COUNT_W'(i));
			assign masked[8*i +: 8] = keep ? mixed[8*i +: 8] : 8'h00;
			assign lane_cnt[i] = byte_ones(cells[8*i +: 8]);
		end
	endgenerate

	assign spread = masked | (masked >> 2);

	// Fold each cell onto its low bit
	always_comb begin
		cells     = '0;
		supported = 1'b1;
		unique case (cfg.cell_size)
			CELL_BIT:    cells = masked;
			CELL_PAIR:   cells = (masked | (masked >> 1)) & PAIR_MASK;
			CELL_NIBBLE: cells = (spread | (spread >> 1)) & NIBBLE_MASK;
			default:     supported = 1'b0;
		endcase
	end

	// Adder tree over the lane counts
	logic [4:0] sum2 [4];
	logic [5:0] sum4 [2];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum2[k] = {1'b0, lane_cnt[2*k]} + {1'b0, lane_cnt[2*k+1]};
		end
		for (int k = 0; k < 2; k++) begin
			sum4[k] = {1'b0, sum2[2*k]} + {1'b0, sum2[2*k+1]};
		end
	end

	assign entry.cnt       = {1'b0, sum4[0]} + {1'b0, sum4[1]};
	assign entry.supported = supported;
	assign entry.last      = last;

endmodule

/* src/hcd_queue.sv */
// Two-entry queue between front and back
module hcd_queue import hcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  hcd_entry_t wr_entry,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output hcd_entry_t rd_entry
);

	localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

	hcd_entry_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0]  level_q;

	assign full      = (level_q == LEVEL_W'(QUEUE_DEPTH));
	assign not_empty = (level_q != '0);
	assign rd_entry  = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

/* src/hcd_back.sv */
// Back part: saturating running total and the result output register
module hcd_back import hcd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  hcd_entry_t      head,
	output logic            pop,
	hcd_result_if.source    res
);

	logic [DIST_W-1:0] total_q;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] total_next;
	logic              res_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic              status_q;
	logic              out_free;

	assign out_free = !res_valid_q || res.ready;
	// Non-last items never wait; a last item waits for room in the output register
	assign pop = head_valid && (!head.last || out_free);

	// Saturating add
	assign sum = {1'b0, total_q} + (DIST_W + 1)'(head.cnt);
	always_comb begin
		total_next = total_q;
		if (head.supported) begin
			total_next = sum[DIST_W] ? TOTAL_MAX : sum[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				total_q <= head.last ? '0 : total_next;
			end
			if (pop && head.last) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			distance_q <= head.supported ? total_next : '0;
			status_q   <= head.supported ? STATUS_OK : STATUS_UNSUPPORTED;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.distance = distance_q;
	assign res.status   = status_q;

endmodule

/* src/hamming_cell_distance_top.sv */
// Top level of the cell Hamming distance block
//
//  channel  dir  payload                                   handshake
//  vec      in   operand_a, operand_b, byte_count, last    valid/ready
//  res      out  distance, status                          valid/ready
//  cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// One item per cycle sustained while the queue has room. The front counts
// an item in the cycle it is taken and writes it to a two-entry queue; the
// back totals it as it leaves the queue, and a last item sets the result.
// Reset clears the total, the queue and the output register, and sets
// cell_size to 1 and diff_mode to 1. A stalled result holds the back only
// on last items; vec.ready drops once the queue fills.
module hamming_cell_distance_top import hcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	hcd_item_if.sink         vec,
	hcd_result_if.source     res
);

	hcd_cfg_t   cfg_q;
	hcd_entry_t front_entry;
	hcd_entry_t head;
	logic       queue_full;
	logic       head_valid;
	logic       pop;
	logic       push;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size <= CELL_BIT;
			cfg_q.diff_mode <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == REG_CELL_SIZE) begin
				cfg_q.cell_size <= cfg_wdata;
			end else begin
				cfg_q.diff_mode <= cfg_wdata[0];
			end
		end
	end

	assign vec.ready = !queue_full;
	assign push      = vec.valid && !queue_full;

	hcd_front u_front (
		.operand_a  (vec.operand_a),
		.operand_b  (vec.operand_b),
		.byte_count (vec.byte_count),
		.last       (vec.last),
		.cfg        (cfg_q),
		.entry      (front_entry)
	);

	hcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (front_entry),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (head_valid),
		.rd_entry  (head)
	);

	hcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

endmodule

/* src/hcd_checker.sv */
// Port-level checker for the cell Hamming distance block, with its bind
`include "assert_macros.svh"

module hcd_checker import hcd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              vec_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [DIST_W-1:0] res_distance,
	input logic              res_status
);

	// An unsupported result never carries a count
	`ASSERT_IMPLIES(a_unsupported_zero, clk, arst_n, res_valid && res_status, res_distance == '0)

	// The queue only fills behind a waiting result
	`ASSERT_IMPLIES(a_full_needs_result, clk, arst_n, !vec_ready, res_valid)

	// A stalled result holds
	`ASSERT_NEXT(a_result_holds, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_distance) && $stable(res_status))

endmodule

bind hamming_cell_distance_top hcd_checker u_hcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vec_ready    (vec.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_distance (res.distance),
	.res_status   (res.status)
);
